// File: src/qte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the CORDIC angle table of the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int QW      = 32;  // quaternion component, Q30
	localparam int PITCH_W = 25;
	localparam int ROLL_W  = 24;
	localparam int YAW_W   = 25;
	localparam int PROD_W  = 64;  // Q60 squares and products
	localparam int OP_W    = 32;  // atan2 operands, Q30
	localparam int CW      = 36;  // CORDIC x and y, room for gain and sign
	localparam int ANG_W   = 34;  // degrees Q24
	localparam int RAD_W   = 61;  // radicand, at most 2^60
	localparam int ROOT_W  = (RAD_W + 1) / 2;

	localparam int CORDIC_STAGES_DEF = 24;

	localparam logic signed [PROD_W-1:0] ONE_Q60       = 64'sh1000_0000_0000_0000;
	localparam logic signed [ANG_W-1:0]  HALF_TURN_Q24 = 34'sd3019898880;
	localparam logic signed [ANG_W:0]    LIM180_Q16    = 35'sd11796480;
	localparam logic signed [ANG_W:0]    LIM90_Q16     = 35'sd5898240;
	localparam logic [PROD_W-1:0]        RAD_TO_DEG_Q24 = 64'd961263669;

	// atan(2^-i) in degrees Q24
	function automatic logic signed [ANG_W-1:0] atan_step(input int i);
		logic signed [ANG_W-1:0] r;
		case (i)
			0:  r = 34'sd754974720;
			1:  r = 34'sd445687602;
			2:  r = 34'sd235489088;
			3:  r = 34'sd119537938;
			4:  r = 34'sd60000934;
			5:  r = 34'sd30029716;
			6:  r = 34'sd15018523;
			7:  r = 34'sd7509720;
			8:  r = 34'sd3754917;
			9:  r = 34'sd1877466;
			10: r = 34'sd938734;
			11: r = 34'sd469367;
			12: r = 34'sd234684;
			13: r = 34'sd117342;
			14: r = 34'sd58671;
			15: r = 34'sd29335;
			default: r = ANG_W'(RAD_TO_DEG_Q24 >> i);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/qte_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_in_if
// Quaternion input channel: valid, ready and the three vector components.
// ----------------------------------------------------------------------------
interface qte_in_if import qte_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;

	modport source(output valid, output quat_x, output quat_y, output quat_z, input ready);
	modport sink(input valid, input quat_x, input quat_y, input quat_z, output ready);
endinterface
`default_nettype wire

// File: src/qte_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_out_if
// Euler angle output channel: valid, ready and the three angles with flag.
// ----------------------------------------------------------------------------
interface qte_out_if import qte_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [PITCH_W-1:0] pitch_deg;
	logic signed [ROLL_W-1:0]  roll_deg;
	logic signed [YAW_W-1:0]   yaw_deg;
	logic                      angles_valid;

	modport source(output valid, output pitch_deg, output roll_deg, output yaw_deg,
		output angles_valid, input ready);
	modport sink(input valid, input pitch_deg, input roll_deg, input yaw_deg,
		input angles_valid, output ready);
endinterface
`default_nettype wire

// File: src/qte_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined digit-by-digit integer square root, one result bit per stage,
// with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; #(
	parameter int IN_W  = RAD_W,
	parameter int TAG_W = 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [IN_W-1:0]              rad,
	input  wire logic [TAG_W-1:0]             tag_in,
	output      logic                         out_valid,
	output      logic [(IN_W+1)/2-1:0]        root,
	output      logic [TAG_W-1:0]             tag_out
);

	localparam int R_W = (IN_W + 1) / 2;
	localparam int V_W = IN_W + 2;

	logic [V_W-1:0]   rem_q  [R_W];
	logic [R_W-1:0]   root_q [R_W];
	logic [TAG_W-1:0] tag_q  [R_W];
	logic             vld_q  [R_W];

	for (genvar j = 0; j < R_W; j++) begin : g_step
		localparam int B = R_W - 1 - j;
		logic [V_W-1:0]   rem_i;
		logic [V_W-1:0]   trial;
		logic [R_W-1:0]   root_i;
		logic [TAG_W-1:0] tag_i;
		logic             vld_i;

		if (j == 0) begin : g_first
			assign rem_i  = V_W'(rad);
			assign root_i = '0;
			assign tag_i  = tag_in;
			assign vld_i  = in_valid;
		end else begin : g_next
			assign rem_i  = rem_q[j-1];
			assign root_i = root_q[j-1];
			assign tag_i  = tag_q[j-1];
			assign vld_i  = vld_q[j-1];
		end

		// (2r + 2^b) * 2^b with r holding only the bits above b
		assign trial = (V_W'(root_i) << (B + 1)) + (V_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (en) begin
				vld_q[j] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= trial) begin
					rem_q[j]  <= rem_i - trial;
					root_q[j] <= root_i | (R_W'(1) << B);
				end else begin
					rem_q[j]  <= rem_i;
					root_q[j] <= root_i;
				end
				tag_q[j] <= tag_i;
			end
		end
	end

	assign out_valid = vld_q[R_W-1];
	assign root      = root_q[R_W-1];
	assign tag_out   = tag_q[R_W-1];

endmodule
`default_nettype wire

// File: src/qte_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees Q24: one
// quadrant-fold stage and one stage per rotation.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF,
	parameter int TAG_W  = 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic signed [OP_W-1:0]  y,
	input  wire logic signed [OP_W-1:0]  x,
	input  wire logic [TAG_W-1:0]        tag_in,
	output      logic                    out_valid,
	output      logic signed [ANG_W-1:0] angle,
	output      logic [TAG_W-1:0]        tag_out
);

	logic signed [CW-1:0]    x_s0, y_s0;
	logic signed [ANG_W-1:0] z_s0;
	logic                    zero_s0, vld_s0;
	logic [TAG_W-1:0]        tag_s0;

	logic signed [CW-1:0]    x_q    [STAGES];
	logic signed [CW-1:0]    y_q    [STAGES];
	logic signed [ANG_W-1:0] z_q    [STAGES];
	logic                    zero_q [STAGES];
	logic                    vld_q  [STAGES];
	logic [TAG_W-1:0]        tag_q  [STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	// fold the left half-plane onto the right with a half-turn preload
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s0 <= (x == '0) && (y == '0);
			tag_s0  <= tag_in;
			if (x < 0) begin
				x_s0 <= -CW'(x);
				y_s0 <= -CW'(y);
				z_s0 <= (y < 0) ? -HALF_TURN_Q24 : HALF_TURN_Q24;
			end else begin
				x_s0 <= CW'(x);
				y_s0 <= CW'(y);
				z_s0 <= '0;
			end
		end
	end

	for (genvar j = 0; j < STAGES; j++) begin : g_rot
		logic signed [CW-1:0]    x_i, y_i;
		logic signed [ANG_W-1:0] z_i;
		logic                    zero_i, vld_i;
		logic [TAG_W-1:0]        tag_i;

		if (j == 0) begin : g_first
			assign x_i    = x_s0;
			assign y_i    = y_s0;
			assign z_i    = z_s0;
			assign zero_i = zero_s0;
			assign vld_i  = vld_s0;
			assign tag_i  = tag_s0;
		end else begin : g_next
			assign x_i    = x_q[j-1];
			assign y_i    = y_q[j-1];
			assign z_i    = z_q[j-1];
			assign zero_i = zero_q[j-1];
			assign vld_i  = vld_q[j-1];
			assign tag_i  = tag_q[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (en) begin
				vld_q[j] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_i < 0) begin
					x_q[j] <= x_i - (y_i >>> j);
					y_q[j] <= y_i + (x_i >>> j);
					z_q[j] <= z_i - atan_step(j);
				end else begin
					x_q[j] <= x_i + (y_i >>> j);
					y_q[j] <= y_i - (x_i >>> j);
					z_q[j] <= z_i + atan_step(j);
				end
				zero_q[j] <= zero_i;
				tag_q[j]  <= tag_i;
			end
		end
	end

	assign out_valid = vld_q[STAGES-1];
	assign angle     = zero_q[STAGES-1] ? '0 : z_q[STAGES-1];
	assign tag_out   = tag_q[STAGES-1];

endmodule
`default_nettype wire

// File: src/quaternion_to_euler_angles.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Rebuilds the scalar part of a unit quaternion and converts it to pitch,
// roll and yaw in degrees Q16 through two root pipelines and three CORDICs.
// ----------------------------------------------------------------------------
// path: the item runs through the two 31-stage square root pipelines and
//   the CORDIC rotation stages
// throughput: one item per cycle; the whole pipeline holds while the output
//   register is full and not taken
// reset: arst_n clears every valid bit at once; no clearing pass
module quaternion_to_euler_angles import qte_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	qte_in_if.sink     quat,
	qte_out_if.source  angles
);

	localparam int TAG_A_W = 1 + 3 * QW + 3 * PROD_W + 2 * OP_W;
	localparam int TAG_B_W = 1 + 5 * OP_W;

	logic en;

	// stage 1: input register
	logic signed [QW-1:0] x_s1, y_s1, z_s1;
	logic                 vld_s1;
	// stage 2: squares and cross products
	logic signed [PROD_W-1:0] xx_s2, yy_s2, zz_s2, yz_s2, zx_s2, xy_s2;
	logic signed [QW-1:0]     x_s2, y_s2, z_s2;
	logic                     vld_s2;
	// stage 3: radicand of w and the atan2 denominators
	logic [PROD_W-1:0]        sum_c;
	logic signed [PROD_W-1:0] t1_c, t4_c;
	logic [RAD_W-1:0]         rad_s3;
	logic                     inv_s3, vld_s3;
	logic signed [QW-1:0]     x_s3, y_s3, z_s3;
	logic signed [PROD_W-1:0] yz_s3, zx_s3, xy_s3;
	logic signed [OP_W-1:0]   t1q_s3, t4q_s3;
	// root of w
	logic [ROOT_W-1:0]        w_a;
	logic                     vld_a, inv_a;
	logic signed [QW-1:0]     x_a, y_a, z_a;
	logic signed [PROD_W-1:0] yz_a, zx_a, xy_a;
	logic signed [OP_W-1:0]   t1q_a, t4q_a;
	logic [TAG_A_W-1:0]       tag_a;
	// stage 4: products with w
	logic signed [PROD_W-1:0] wx_s4, wy_s4, wz_s4, yz_s4, zx_s4, xy_s4;
	logic signed [OP_W-1:0]   t1q_s4, t4q_s4;
	logic                     inv_s4, vld_s4;
	// stage 5: numerators
	logic signed [PROD_W-1:0] t0_c, t2_c, t2c_c, t3_c;
	logic signed [OP_W-1:0]   t0q_s5, t1q_s5, t3q_s5, t4q_s5, s_s5;
	logic                     inv_s5, vld_s5;
	// stage 6: square of the roll sine
	logic signed [PROD_W-1:0] ss_s6;
	logic signed [OP_W-1:0]   t0q_s6, t1q_s6, t3q_s6, t4q_s6, s_s6;
	logic                     inv_s6, vld_s6;
	logic [PROD_W-1:0]        rad2_c;
	// root of the roll cosine
	logic [ROOT_W-1:0]        c_b;
	logic                     vld_b, inv_b;
	logic signed [OP_W-1:0]   t0q_b, t1q_b, t3q_b, t4q_b, s_b;
	logic [TAG_B_W-1:0]       tag_b;
	// CORDIC lanes
	logic signed [ANG_W-1:0]  pitch_a, roll_a, yaw_a;
	logic                     vld_p, vld_r, vld_y, inv_p, inv_r, inv_y;
	// output register
	logic signed [PITCH_W-1:0] pitch_q;
	logic signed [ROLL_W-1:0]  roll_q;
	logic signed [YAW_W-1:0]   yaw_q;
	logic                      ok_q, vld_q;

	function automatic logic signed [ANG_W:0] to_q16(input logic signed [ANG_W:0] a,
		input logic signed [ANG_W:0] lim);
		logic signed [ANG_W:0] r;
		r = (a + (ANG_W+1)'(128)) >>> 8;
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

	assign en         = !vld_q || angles.ready;
	assign quat.ready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= quat.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_a;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_q  <= vld_p & vld_r & vld_y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= quat.quat_x;
			y_s1 <= quat.quat_y;
			z_s1 <= quat.quat_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2 <= PROD_W'(x_s1) * PROD_W'(x_s1);
			yy_s2 <= PROD_W'(y_s1) * PROD_W'(y_s1);
			zz_s2 <= PROD_W'(z_s1) * PROD_W'(z_s1);
			yz_s2 <= PROD_W'(y_s1) * PROD_W'(z_s1);
			zx_s2 <= PROD_W'(z_s1) * PROD_W'(x_s1);
			xy_s2 <= PROD_W'(x_s1) * PROD_W'(y_s1);
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			z_s2  <= z_s1;
		end
	end

	// squares are non-negative, so the sum fits unsigned 64 bits
	assign sum_c = $unsigned(xx_s2) + $unsigned(yy_s2) + $unsigned(zz_s2);
	assign t1_c  = ONE_Q60 - ((xx_s2 + yy_s2) <<< 1);
	assign t4_c  = ONE_Q60 - ((yy_s2 + zz_s2) <<< 1);

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s3 <= sum_c > $unsigned(ONE_Q60);
			rad_s3 <= (sum_c > $unsigned(ONE_Q60)) ? '0 :
				RAD_W'($unsigned(ONE_Q60) - sum_c);
			t1q_s3 <= OP_W'(t1_c >>> 30);
			t4q_s3 <= OP_W'(t4_c >>> 30);
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			yz_s3  <= yz_s2;
			zx_s3  <= zx_s2;
			xy_s3  <= xy_s2;
		end
	end

	qte_isqrt #(
		.IN_W (RAD_W),
		.TAG_W(TAG_A_W)
	) u_root_w (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.rad      (rad_s3),
		.tag_in   ({inv_s3, x_s3, y_s3, z_s3, yz_s3, zx_s3, xy_s3, t1q_s3, t4q_s3}),
		.out_valid(vld_a),
		.root     (w_a),
		.tag_out  (tag_a)
	);

	assign {inv_a, x_a, y_a, z_a, yz_a, zx_a, xy_a, t1q_a, t4q_a} = tag_a;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s4  <= PROD_W'($signed({1'b0, w_a})) * PROD_W'(x_a);
			wy_s4  <= PROD_W'($signed({1'b0, w_a})) * PROD_W'(y_a);
			wz_s4  <= PROD_W'($signed({1'b0, w_a})) * PROD_W'(z_a);
			yz_s4  <= yz_a;
			zx_s4  <= zx_a;
			xy_s4  <= xy_a;
			t1q_s4 <= t1q_a;
			t4q_s4 <= t4q_a;
			inv_s4 <= inv_a;
		end
	end

	assign t0_c  = (wx_s4 + yz_s4) <<< 1;
	assign t2_c  = (wy_s4 - zx_s4) <<< 1;
	assign t3_c  = (wz_s4 + xy_s4) <<< 1;
	assign t2c_c = (t2_c > ONE_Q60) ? ONE_Q60 : ((t2_c < -ONE_Q60) ? -ONE_Q60 : t2_c);

	always_ff @(posedge clk) begin
		if (en) begin
			t0q_s5 <= OP_W'(t0_c >>> 30);
			t3q_s5 <= OP_W'(t3_c >>> 30);
			s_s5   <= OP_W'(t2c_c >>> 30);
			t1q_s5 <= t1q_s4;
			t4q_s5 <= t4q_s4;
			inv_s5 <= inv_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s6  <= PROD_W'(s_s5) * PROD_W'(s_s5);
			s_s6   <= s_s5;
			t0q_s6 <= t0q_s5;
			t1q_s6 <= t1q_s5;
			t3q_s6 <= t3q_s5;
			t4q_s6 <= t4q_s5;
			inv_s6 <= inv_s5;
		end
	end

	assign rad2_c = $unsigned(ONE_Q60 - ss_s6);

	qte_isqrt #(
		.IN_W (RAD_W),
		.TAG_W(TAG_B_W)
	) u_root_c (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s6),
		.rad      (rad2_c[RAD_W-1:0]),
		.tag_in   ({inv_s6, t0q_s6, t1q_s6, t3q_s6, t4q_s6, s_s6}),
		.out_valid(vld_b),
		.root     (c_b),
		.tag_out  (tag_b)
	);

	assign {inv_b, t0q_b, t1q_b, t3q_b, t4q_b, s_b} = tag_b;

	qte_cordic #(
		.STAGES(CORDIC_STAGES),
		.TAG_W (1)
	) u_cordic_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_b),
		.y        (t0q_b),
		.x        (t1q_b),
		.tag_in   (inv_b),
		.out_valid(vld_p),
		.angle    (pitch_a),
		.tag_out  (inv_p)
	);

	qte_cordic #(
		.STAGES(CORDIC_STAGES),
		.TAG_W (1)
	) u_cordic_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_b),
		.y        (s_b),
		.x        ($signed(OP_W'(c_b))),
		.tag_in   (inv_b),
		.out_valid(vld_r),
		.angle    (roll_a),
		.tag_out  (inv_r)
	);

	qte_cordic #(
		.STAGES(CORDIC_STAGES),
		.TAG_W (1)
	) u_cordic_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_b),
		.y        (t3q_b),
		.x        (t4q_b),
		.tag_in   (inv_b),
		.out_valid(vld_y),
		.angle    (yaw_a),
		.tag_out  (inv_y)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if (inv_p | inv_r | inv_y) begin
				pitch_q <= '0;
				roll_q  <= '0;
				yaw_q   <= '0;
				ok_q    <= 1'b0;
			end else begin
				pitch_q <= PITCH_W'(to_q16((ANG_W+1)'(pitch_a), LIM180_Q16));
				roll_q  <= ROLL_W'(to_q16((ANG_W+1)'(roll_a), LIM90_Q16));
				yaw_q   <= YAW_W'(to_q16(-((ANG_W+1)'(yaw_a)), LIM180_Q16));
				ok_q    <= 1'b1;
			end
		end
	end

	assign angles.valid        = vld_q;
	assign angles.pitch_deg    = pitch_q;
	assign angles.roll_deg     = roll_q;
	assign angles.yaw_deg      = yaw_q;
	assign angles.angles_valid = ok_q;

	// a held result must stall the input side
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && !angles.ready) |-> !quat.ready)
		else $error("input taken while result stalled");

	// flagged results carry zero angles
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && !ok_q) |-> (pitch_q == '0 && roll_q == '0 && yaw_q == '0))
		else $error("invalid result with non-zero angle");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (roll_q <= 24'sd5898240 && roll_q >= -24'sd5898240))
		else $error("roll out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (pitch_q <= 25'sd11796480 && pitch_q >= -25'sd11796480))
		else $error("pitch out of range");

endmodule
`default_nettype wire

// File: tb/qte_checker.sv
// ----------------------------------------------------------------------------
// qte_checker
// Watches the quaternion and angle channels, works out the expected Euler
// angles of every accepted quaternion and compares them with the results.
// ----------------------------------------------------------------------------
module qte_checker import qte_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	qte_in_if         quat,
	qte_out_if        angles,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [PITCH_W-1:0] pitch;
		logic signed [ROLL_W-1:0]  roll;
		logic signed [YAW_W-1:0]   yaw;
		logic                      ok;
	} euler_t;

	euler_t angle_queue[$];

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic longint atan2_deg(longint y, longint x);
		longint z, dx, dy, st;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y < 0) ? -(longint'(180) << 24) : (longint'(180) << 24);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			st = longint'(atan_step(i));
			dx = floor_shr(x, i);
			dy = floor_shr(y, i);
			if (y < 0) begin
				x = x - dy; y = y + dx; z = z - st;
			end else begin
				x = x + dy; y = y - dx; z = z + st;
			end
		end
		return z;
	endfunction

	function automatic longint deg_q16(longint a, longint lim);
		longint r;
		r = floor_shr(a + 128, 8);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic euler_t euler_of(logic signed [QW-1:0] qx, logic signed [QW-1:0] qy,
			logic signed [QW-1:0] qz);
		longint x, y, z, w, t0, t1, t2, t3, t4, s, c, one;
		longint unsigned sum;
		euler_t e;
		x = qx; y = qy; z = qz;
		one = longint'(1) << 60;
		sum = longint'(x * x) + longint'(y * y) + longint'(z * z);
		e = '0;
		if (sum > longint'(one))
			return e;
		w = int_sqrt(one - sum);
		t0 = 2 * (w * x + y * z);
		t1 = one - 2 * (x * x + y * y);
		e.pitch = PITCH_W'(deg_q16(atan2_deg(floor_shr(t0, 30), floor_shr(t1, 30)), 11796480));
		t2 = 2 * (w * y - z * x);
		if (t2 > one) t2 = one;
		if (t2 < -one) t2 = -one;
		s = floor_shr(t2, 30);
		c = int_sqrt(one - s * s);
		e.roll = ROLL_W'(deg_q16(atan2_deg(s, c), 5898240));
		t3 = 2 * (w * z + x * y);
		t4 = one - 2 * (y * y + z * z);
		e.yaw = YAW_W'(deg_q16(-atan2_deg(floor_shr(t3, 30), floor_shr(t4, 30)), 11796480));
		e.ok = 1'b1;
		return e;
	endfunction

	initial errors = 0;
	assign pending = angle_queue.size();

	always @(posedge clk) begin
		euler_t e, got;
		if (arst_n && quat.valid && quat.ready)
			angle_queue.push_back(euler_of(quat.quat_x, quat.quat_y, quat.quat_z));
		if (arst_n && angles.valid && angles.ready) begin
			got = {angles.pitch_deg, angles.roll_deg, angles.yaw_deg, angles.angles_valid};
			if (angle_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected item %h", $time, got);
			end else begin
				e = angle_queue.pop_front();
				if (e.pitch !== got.pitch) begin
					errors++;
					$display("%0t: pitch expected %0d got %0d", $time, e.pitch, got.pitch);
				end
				if (e.roll !== got.roll) begin
					errors++;
					$display("%0t: roll expected %0d got %0d", $time, e.roll, got.roll);
				end
				if (e.yaw !== got.yaw) begin
					errors++;
					$display("%0t: yaw expected %0d got %0d", $time, e.yaw, got.yaw);
				end
				if (e.ok !== got.ok) begin
					errors++;
					$display("%0t: valid flag expected %0b got %0b", $time, e.ok, got.ok);
				end
			end
		end
	end
endmodule

// File: tb/quaternion_to_euler_angles_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Drives directed and random quaternions, unit and non-unit, with random
// gaps on both channels; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qte_pkg::*;

	localparam int LATENCY = 70 + CORDIC_STAGES_DEF;
	localparam int ONE = 1 << 30;

	logic clk;
	logic arst_n;
	int   errors, pending, n_sent;
	bit   calm;

	qte_in_if  quat();
	qte_out_if angles();

	quaternion_to_euler_angles u_dut (.clk(clk), .arst_n(arst_n), .quat(quat), .angles(angles));
	qte_checker u_chk (.clk(clk), .arst_n(arst_n), .quat(quat), .angles(angles),
		.errors(errors), .pending(pending));

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("quaternion_to_euler_angles_tb: done, errors");
		$finish;
	end

	// receiver stalls, none during the calm stretch
	always @(negedge clk)
		angles.ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);

	// valid stays high after an item so that the next can follow at once
	task automatic send(int x, int y, int z);
		while (!calm && $urandom_range(99) < 24) begin
			quat.valid <= 1'b0;
			@(negedge clk);
		end
		quat.valid  <= 1'b1;
		quat.quat_x <= x;
		quat.quat_y <= y;
		quat.quat_z <= z;
		@(posedge clk);
		while (!quat.ready)
			@(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	// random unit-length quaternion vector part, scaled by a random fraction
	task automatic send_unit();
		real a, b, c, n, k;
		a = real'(int'($urandom)) ; b = real'(int'($urandom)); c = real'(int'($urandom));
		n = $sqrt(a * a + b * b + c * c);
		if (n == 0.0) n = 1.0;
		k = ($urandom_range(3) == 0) ? 1.0 : real'($urandom_range(1000)) / 1000.0;
		send(int'(a / n * k * 0.999999 * ONE), int'(b / n * k * 0.999999 * ONE),
			int'(c / n * k * 0.999999 * ONE));
	endtask

	initial begin
		arst_n = 0;
		calm = 0;
		n_sent = 0;
		quat.valid = 0;
		quat.quat_x = 0;
		quat.quat_y = 0;
		quat.quat_z = 0;
		angles.ready = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: zeros, axes, extremes, exactly one, gimbal lock, over one
		send(0, 0, 0);
		send(ONE, 0, 0);
		send(-ONE, 0, 0);
		send(0, ONE, 0);
		send(0, -ONE, 0);
		send(0, 0, ONE);
		send(0, 0, -ONE);
		send(32'sh7fffffff, 0, 0);
		send(32'sh80000000, 32'sh80000000, 32'sh80000000);
		send(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send(759250125, 759250125, 0);
		send(759250125, 0, 759250125);
		send(0, 759250125, 759250124);
		send(536870912, 536870912, 536870912);
		send(620000000, 620000000, 620000000);
		send(-1, -1, -1);
		send(1, 0, -1);
		send(759250124, -759250124, 1);
		send(-536870912, 929887697, 0);
		quat.valid <= 1'b0;
		wait (pending == 0);
		repeat (LATENCY) @(negedge clk);
		for (int i = 0; i < 1000; i++) begin
			calm = (i >= 400 && i < 550);
			if (i == 700) begin
				quat.valid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			case ($urandom_range(9))
				0:       send($urandom, $urandom, $urandom);
				1:       send($urandom_range(3) - 2, $urandom_range(3) - 2, $urandom_range(3) - 2);
				default: send_unit();
			endcase
		end
		quat.valid <= 1'b0;
		calm = 0;
		wait (pending == 0);
		repeat (LATENCY + 10) @(negedge clk);
		if (errors == 0)
			$display("quaternion_to_euler_angles_tb: done, clean");
		else
			$display("quaternion_to_euler_angles_tb: done, errors");
		$finish;
	end
endmodule
